>>> hw/rtl/ipacl_pkg.sv
// Shared types and constants for the IP prefix access list.
package ipacl_pkg;

  // Address family widths in bits.
  localparam int unsigned V4Bits = 32;
  localparam int unsigned V6Bits = 128;

  // Operation codes of an input word.
  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_APPEND = 1'b1
  } acl_op_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_WILDCARD = 2'd1,
    ST_FULL     = 2'd2,
    ST_TOO_LONG = 2'd3
  } acl_status_e;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_HOLD
  } acl_state_e;

  // Input word.
  typedef struct packed {
    acl_op_e     operation;
    logic        is_ipv6;
    logic [63:0] address_high;
    logic [63:0] address_low;
    logic [7:0]  prefix_len;
  } acl_in_t;

  // Output word.
  typedef struct packed {
    logic        hit;
    logic [5:0]  entry_index;
    acl_status_e status;
  } acl_out_t;

  // Search key: family and address, left aligned so that an IPv4 address
  // occupies the top 32 bits and prefix masks are the same for both families.
  typedef struct packed {
    logic         is_ipv6;
    logic [127:0] addr;
  } acl_key_t;

endpackage

>>> hw/rtl/ipacl_cell.sv
// One rule cell of the access list chain: holds a rule and checks a passing key.
module ipacl_cell
  import ipacl_pkg::*;
#(
  parameter int unsigned CntW = 7,
  parameter int unsigned IdxW = 6
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // Rule write port.
  input  logic            wr_en_i,
  input  acl_key_t        wr_key_i,
  input  logic [7:0]      wr_plen_i,
  // Key token from the previous cell.
  input  logic            tok_valid_i,
  input  acl_key_t        tok_key_i,
  input  logic [CntW-1:0] tok_left_i,
  input  logic [IdxW-1:0] tok_pos_i,
  input  logic            tok_found_i,
  input  logic [IdxW-1:0] tok_fidx_i,
  // Key token to the next cell.
  output logic            tok_valid_o,
  output acl_key_t        tok_key_o,
  output logic [CntW-1:0] tok_left_o,
  output logic [IdxW-1:0] tok_pos_o,
  output logic            tok_found_o,
  output logic [IdxW-1:0] tok_fidx_o
);

  // Stored rule.
  acl_key_t        rule_key_q;
  logic [7:0]      rule_plen_q;

  // Token stage registers.
  logic            tok_valid_q, tok_valid_d;
  acl_key_t        tok_key_q, tok_key_d;
  logic [CntW-1:0] tok_left_q, tok_left_d;
  logic [IdxW-1:0] tok_pos_q, tok_pos_d;
  logic            tok_found_q, tok_found_d;
  logic [IdxW-1:0] tok_fidx_q, tok_fidx_d;

  logic [127:0]    mask;
  logic            rule_hit;

  // Rule storage is written once per append and needs no reset.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      rule_key_q  <= wr_key_i;
      rule_plen_q <= wr_plen_i;
    end
  end

  // Prefix mask: the top rule_plen_q bits of the aligned address.
  always_comb begin
    for (int i = 0; i < 128; i++) begin
      mask[i] = (8'(127 - i) < rule_plen_q);
    end
  end

  // The rule takes part only while the token still covers stored rules.
  assign rule_hit = (tok_left_i != '0) &&
                    (rule_key_q.is_ipv6 == tok_key_i.is_ipv6) &&
                    (((rule_key_q.addr ^ tok_key_i.addr) & mask) == '0);

  // Next token: the first hit along the chain is kept.
  always_comb begin
    tok_valid_d = tok_valid_i;
    tok_key_d   = tok_key_i;
    tok_left_d  = (tok_left_i == '0) ? tok_left_i : tok_left_i - CntW'(1);
    tok_pos_d   = tok_pos_i + IdxW'(1);
    tok_found_d = tok_found_i | rule_hit;
    tok_fidx_d  = (!tok_found_i && rule_hit) ? tok_pos_i : tok_fidx_i;
  end

  // Valid flag resets; the rest of the token is payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_valid_q <= 1'b0;
    end else begin
      tok_valid_q <= tok_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_key_q   <= tok_key_d;
    tok_left_q  <= tok_left_d;
    tok_pos_q   <= tok_pos_d;
    tok_found_q <= tok_found_d;
    tok_fidx_q  <= tok_fidx_d;
  end

  assign tok_valid_o = tok_valid_q;
  assign tok_key_o   = tok_key_q;
  assign tok_left_o  = tok_left_q;
  assign tok_pos_o   = tok_pos_q;
  assign tok_found_o = tok_found_q;
  assign tok_fidx_o  = tok_fidx_q;

endmodule

>>> hw/rtl/ip_prefix_acl_first_match_core.sv
// Top level of the IP prefix access list with first-match lookup.
//
// Usage: words enter on the in channel (valid/ready) and one result word per
// input word leaves on the out channel (valid/ready). An append word stores a
// rule at the end of the list or rejects it with a status code; a lookup word
// returns the index of the first stored rule, in insertion order, of the same
// family whose prefix matches the address.
// Rules live in a chain of ENTRIES cells. A lookup key walks the chain one
// cell per cycle; when it leaves the last cell its result is registered and
// then moved to the output register, after which the next word is taken. An
// append writes its cell directly; its result is registered on acceptance and
// is then moved to the output register before the next word is taken.
// One word is in progress at a time; the next word is accepted while the
// previous result still waits in the output register.
// Reset empties the list (rule count zero) and clears all valid flags; rule
// contents are not cleared. When the receiver stalls, the output word holds
// and at most one finished result waits behind it before input is held off.
module ip_prefix_acl_first_match_core
  import ipacl_pkg::*;
#(
  parameter int unsigned ENTRIES = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  acl_in_t  in_word_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output acl_out_t out_word_o
);

  localparam int unsigned CntW = $clog2(ENTRIES + 1);
  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  acl_state_e      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  acl_out_t        res_q, res_d;
  acl_out_t        out_q, out_d;
  logic            out_valid_q, out_valid_d;

  logic            accept;
  logic            inject;
  logic            wr_go;
  logic            out_move;
  logic            tail_valid;

  logic [63:0]     key_hi;
  logic [63:0]     key_lo;
  acl_key_t        key;
  acl_status_e     app_status;

  // Chain token links; index 0 is fed by the controller.
  logic            tok_valid [ENTRIES+1];
  acl_key_t        tok_key   [ENTRIES+1];
  logic [CntW-1:0] tok_left  [ENTRIES+1];
  logic [IdxW-1:0] tok_pos   [ENTRIES+1];
  logic            tok_found [ENTRIES+1];
  logic [IdxW-1:0] tok_fidx  [ENTRIES+1];

  // Family-dependent address and left-aligned key.
  assign key_hi      = in_word_i.is_ipv6 ? in_word_i.address_high : 64'd0;
  assign key_lo      = in_word_i.is_ipv6 ? in_word_i.address_low
                                         : {32'd0, in_word_i.address_low[31:0]};
  assign key.is_ipv6 = in_word_i.is_ipv6;
  assign key.addr    = in_word_i.is_ipv6 ? {key_hi, key_lo}
                                         : {key_lo[31:0], 96'd0};

  // Append checks in order: prefix length, wildcard rule, full table.
  always_comb begin
    if (in_word_i.prefix_len > (in_word_i.is_ipv6 ? 8'(V6Bits) : 8'(V4Bits))) begin
      app_status = ST_TOO_LONG;
    end else if (key_hi == '0 && key_lo == '0 && in_word_i.prefix_len == '0) begin
      app_status = ST_WILDCARD;
    end else if (cnt_q >= CntW'(ENTRIES)) begin
      app_status = ST_FULL;
    end else begin
      app_status = ST_OK;
    end
  end

  assign tail_valid = tok_valid[ENTRIES];
  assign out_move   = (state_q == S_HOLD) && (!out_valid_q || out_ready_i);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_word_i.operation == OP_LOOKUP) ? S_SEARCH : S_HOLD;
        end
      end
      S_SEARCH: begin
        if (tail_valid) begin
          state_d = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_move) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Controller outputs.
  always_comb begin
    in_ready_o = (state_q == S_IDLE);
    accept     = in_valid_i && in_ready_o;
    inject     = accept && (in_word_i.operation == OP_LOOKUP);
    wr_go      = accept && (in_word_i.operation == OP_APPEND) && (app_status == ST_OK);
  end

  // Result, rule count and output register updates.
  always_comb begin
    res_d       = res_q;
    cnt_d       = cnt_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (accept && in_word_i.operation == OP_APPEND) begin
      res_d.hit         = 1'b0;
      res_d.entry_index = (app_status == ST_OK) ? 6'(cnt_q) : 6'd0;
      res_d.status      = app_status;
    end else if (state_q == S_SEARCH && tail_valid) begin
      res_d.hit         = tok_found[ENTRIES];
      res_d.entry_index = 6'(tok_fidx[ENTRIES]);
      res_d.status      = ST_OK;
    end
    if (wr_go) begin
      cnt_d = cnt_q + CntW'(1);
    end
    if (out_move) begin
      out_d       = res_q;
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // Head of the chain.
  assign tok_valid[0] = inject;
  assign tok_key[0]   = key;
  assign tok_left[0]  = cnt_q;
  assign tok_pos[0]   = '0;
  assign tok_found[0] = 1'b0;
  assign tok_fidx[0]  = '0;

  // Row of rule cells; the cell at the current rule count takes an append.
  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    logic cell_wr;

    assign cell_wr = wr_go && (cnt_q == CntW'(k));

    ipacl_cell #(
      .CntW (CntW),
      .IdxW (IdxW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .wr_en_i     (cell_wr),
      .wr_key_i    (key),
      .wr_plen_i   (in_word_i.prefix_len),
      .tok_valid_i (tok_valid[k]),
      .tok_key_i   (tok_key[k]),
      .tok_left_i  (tok_left[k]),
      .tok_pos_i   (tok_pos[k]),
      .tok_found_i (tok_found[k]),
      .tok_fidx_i  (tok_fidx[k]),
      .tok_valid_o (tok_valid[k+1]),
      .tok_key_o   (tok_key[k+1]),
      .tok_left_o  (tok_left[k+1]),
      .tok_pos_o   (tok_pos[k+1]),
      .tok_found_o (tok_found[k+1]),
      .tok_fidx_o  (tok_fidx[k+1])
    );
  end

endmodule

>>> test/tb_ip_prefix_acl_first_match_core.sv
// Self-checking testbench for the IP prefix access list with first-match lookup.
`timescale 1ns / 100ps

module tb_ip_prefix_acl_first_match_core;
  import ipacl_pkg::*;

  localparam int unsigned ENTRIES = 64;
  // Rule count at which random traffic stops appending before the full-table test.
  localparam int unsigned RANDOM_RULE_CAP = 56;
  localparam int unsigned MAX_PRINTED = 50;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  acl_in_t  in_word_i;
  logic     out_valid_o;
  logic     out_ready_i;
  acl_out_t out_word_o;

  // Rule table as the testbench sees it; keys are left aligned like the block's.
  logic         rule_v6 [ENTRIES];
  logic [127:0] rule_key [ENTRIES];
  logic [7:0]   rule_plen [ENTRIES];
  int unsigned  rule_total;

  acl_out_t expected_results [$];
  int unsigned mismatch_count;
  logic idle_on;

  ip_prefix_acl_first_match_core #(
    .ENTRIES(ENTRIES)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Work out the result of one accepted word and update the rule table.
  function automatic acl_out_t predict_acl(input acl_in_t w);
    acl_out_t     r;
    logic [127:0] key;
    logic [127:0] mask;
    r.hit         = 1'b0;
    r.entry_index = '0;
    r.status      = ST_OK;
    // IPv4 uses only the low 32 bits of address_low, placed at the top of the key.
    key = w.is_ipv6 ? {w.address_high, w.address_low} : {w.address_low[31:0], 96'h0};
    if (w.operation == OP_LOOKUP) begin
      for (int i = 0; i < rule_total; i++) begin
        mask = (rule_plen[i] == 0) ? '0 : ~128'h0 << (128 - rule_plen[i]);
        if (rule_v6[i] == w.is_ipv6 && ((rule_key[i] ^ key) & mask) == '0) begin
          r.hit         = 1'b1;
          r.entry_index = 6'(i);
          break;
        end
      end
    end else if (w.prefix_len > (w.is_ipv6 ? V6Bits : V4Bits)) begin
      r.status = ST_TOO_LONG;
    end else if (key == '0 && w.prefix_len == 0) begin
      r.status = ST_WILDCARD;
    end else if (rule_total >= ENTRIES) begin
      r.status = ST_FULL;
    end else begin
      rule_v6[rule_total]   = w.is_ipv6;
      rule_key[rule_total]  = key;
      rule_plen[rule_total] = w.prefix_len;
      r.entry_index         = 6'(rule_total);
      rule_total++;
    end
    return r;
  endfunction

  function automatic acl_in_t build_word(input acl_op_e op, input logic v6,
                                         input logic [63:0] hi, input logic [63:0] lo,
                                         input logic [7:0] plen);
    acl_in_t w;
    w.operation    = op;
    w.is_ipv6      = v6;
    w.address_high = hi;
    w.address_low  = lo;
    w.prefix_len   = plen;
    return w;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTED) begin
      $display("ERROR at %0t ns: %s", $time, msg);
    end
    mismatch_count++;
  endtask

  // Send one word; its expectation is recorded at the edge that accepts it.
  task automatic send_word(input acl_in_t w);
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    expected_results.insert(expected_results.size(), predict_acl(w));
  endtask

  // Stop sending and wait until every outstanding result has come back.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // Append a random rule: mostly well formed, sometimes with any prefix length.
  task automatic send_random_append();
    logic        v6;
    int unsigned plen;
    logic [63:0] hi;
    logic [63:0] lo;
    v6 = 1'($urandom_range(0, 1));
    hi = {$urandom, $urandom};
    lo = {$urandom, $urandom};
    if ($urandom_range(0, 9) < 8) begin
      plen = v6 ? $urandom_range(1, 128) : $urandom_range(1, 32);
    end else begin
      plen = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 255);
      if ($urandom_range(0, 1) == 1) begin
        hi = '0;
        lo = v6 ? 64'h0 : {$urandom, 32'h0};
      end
    end
    send_word(build_word(OP_APPEND, v6, hi, lo, 8'(plen)));
  endtask

  // Look up an address, usually one built from a stored rule so that it hits,
  // sometimes with one prefix bit flipped, otherwise a random address.
  task automatic send_random_lookup();
    logic [127:0] key;
    logic [127:0] noise;
    logic [127:0] mask;
    logic         v6;
    int unsigned  pick;
    int unsigned  bit_pos;
    noise = {$urandom, $urandom, $urandom, $urandom};
    if (rule_total != 0 && $urandom_range(0, 9) < 7) begin
      pick = $urandom_range(0, rule_total - 1);
      v6   = rule_v6[pick];
      mask = (rule_plen[pick] == 0) ? '0 : ~128'h0 << (128 - rule_plen[pick]);
      key  = (rule_key[pick] & mask) | (noise & ~mask);
      if (rule_plen[pick] != 0 && $urandom_range(0, 3) == 0) begin
        bit_pos      = 128 - $urandom_range(1, rule_plen[pick]);
        key[bit_pos] = ~key[bit_pos];
      end
    end else begin
      v6  = 1'($urandom_range(0, 1));
      key = noise;
    end
    if (v6) begin
      send_word(build_word(OP_LOOKUP, 1'b1, key[127:64], key[63:0], 8'($urandom)));
    end else begin
      send_word(build_word(OP_LOOKUP, 1'b0, {$urandom, $urandom}, {$urandom, key[127:96]},
                           8'($urandom)));
    end
  endtask

  task automatic run_random(input int unsigned count, input int unsigned append_pct,
                            input int unsigned rule_cap);
    repeat (count) begin
      if (rule_total < rule_cap && $urandom_range(0, 99) < append_pct) begin
        send_random_append();
      end else begin
        send_random_lookup();
      end
    end
  endtask

  // Empty table: lookups miss, and too-long and wildcard appends are rejected.
  task automatic test_empty_table();
    send_word(build_word(OP_LOOKUP, 1'b0, '1, '1, 8'd0));
    send_word(build_word(OP_LOOKUP, 1'b1, '1, '1, 8'd255));
    send_word(build_word(OP_APPEND, 1'b0, '0, 64'hffff_ffff, 8'd33));
    // A too-long prefix is reported even for the all-zero address.
    send_word(build_word(OP_APPEND, 1'b1, '0, '0, 8'd255));
    send_word(build_word(OP_APPEND, 1'b1, '1, '1, 8'd129));
    // IPv4 upper bits are ignored, so this is still the wildcard rule.
    send_word(build_word(OP_APPEND, 1'b0, '1, 64'hffff_ffff_0000_0000, 8'd0));
    send_word(build_word(OP_APPEND, 1'b1, '0, '0, 8'd0));
  endtask

  // Exact, partial and cross-family matching at the prefix extremes.
  task automatic test_prefix_match();
    send_word(build_word(OP_APPEND, 1'b0, '1, 64'hffff_ffff_0a00_0000, 8'd8));
    send_word(build_word(OP_APPEND, 1'b0, '0, 64'hffff_ffff, 8'd32));
    send_word(build_word(OP_APPEND, 1'b1, '1, '1, 8'd128));
    send_word(build_word(OP_APPEND, 1'b1, 64'h2001_0db8_0000_0000, {$urandom, $urandom},
                         8'd64));
    send_word(build_word(OP_APPEND, 1'b1, '0, '0, 8'd128));
    send_word(build_word(OP_APPEND, 1'b1, '0, 64'h8000_0000_0000_0000, 8'd65));
    send_word(build_word(OP_LOOKUP, 1'b0, '1, 64'h1234_5678_0a12_3456, 8'd0));
    send_word(build_word(OP_LOOKUP, 1'b0, '0, 64'hffff_ffff, 8'd17));
    send_word(build_word(OP_LOOKUP, 1'b0, '0, 64'h0b00_0000, 8'd0));
    send_word(build_word(OP_LOOKUP, 1'b1, '1, '1, 8'd0));
    send_word(build_word(OP_LOOKUP, 1'b1, 64'h2001_0db8_0000_0000, {$urandom, $urandom},
                         8'd200));
    send_word(build_word(OP_LOOKUP, 1'b1, '0, '0, 8'd0));
    send_word(build_word(OP_LOOKUP, 1'b1, '0, 64'h8000_0000_0000_0001, 8'd0));
    send_word(build_word(OP_LOOKUP, 1'b1, '0, 64'h7fff_ffff_ffff_ffff, 8'd0));
    // Same bits as an IPv4 rule but the IPv6 family: no match.
    send_word(build_word(OP_LOOKUP, 1'b1, '0, 64'hffff_ffff, 8'd0));
  endtask

  // Mixed appends and lookups, with one pause until every result is back.
  task automatic test_random_traffic();
    run_random(170, 15, RANDOM_RULE_CAP);
    wait_drained();
    run_random(170, 15, RANDOM_RULE_CAP);
  endtask

  // Catch-all rules, filling the table, and the order of append checks when full.
  task automatic test_table_full();
    wait_drained();
    send_word(build_word(OP_APPEND, 1'b0, '0, 64'h0000_0000_0000_0001, 8'd0));
    send_word(build_word(OP_APPEND, 1'b1, 64'h8000_0000_0000_0000, '0, 8'd0));
    while (rule_total < ENTRIES) send_random_append();
    send_word(build_word(OP_APPEND, 1'b0, '0, 64'hc0a8_0100, 8'd24));
    send_word(build_word(OP_APPEND, 1'b1, '1, '1, 8'd129));
    send_word(build_word(OP_APPEND, 1'b0, '0, '0, 8'd0));
    send_word(build_word(OP_APPEND, 1'b1, 64'h1, '0, 8'd0));
    send_word(build_word(OP_LOOKUP, 1'b0, {$urandom, $urandom}, {$urandom, $urandom}, 8'd0));
    send_word(build_word(OP_LOOKUP, 1'b1, {$urandom, $urandom}, {$urandom, $urandom}, 8'd0));
  endtask

  // Full rate on both sides with a full table.
  task automatic test_full_rate();
    idle_on = 1'b0;
    run_random(150, 20, ENTRIES + 1);
  endtask

  // Receiver stalls in random bursts while idling is enabled.
  always begin
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      out_ready_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    out_ready_i <= 1'b1;
  end

  // Compare each accepted result word with the oldest expectation.
  always @(posedge clk_i) begin : check_results
    acl_out_t exp_w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result word with none expected: hit %0d index %0d status %0d",
                                  out_word_o.hit, out_word_o.entry_index, out_word_o.status));
      end else begin
        exp_w = expected_results.pop_front();
        if (out_word_o.hit !== exp_w.hit) begin
          report_mismatch($sformatf("hit %0d, expected %0d", out_word_o.hit, exp_w.hit));
        end
        if (out_word_o.entry_index !== exp_w.entry_index) begin
          report_mismatch($sformatf("entry_index %0d, expected %0d",
                                    out_word_o.entry_index, exp_w.entry_index));
        end
        if (out_word_o.status !== exp_w.status) begin
          report_mismatch($sformatf("status %0d, expected %0d",
                                    out_word_o.status, exp_w.status));
        end
      end
    end
  end

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_word_i      = '0;
    rule_total     = 0;
    mismatch_count = 0;
    idle_on        = 1'b1;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_table();
    test_prefix_match();
    test_random_traffic();
    test_table_full();
    test_full_rate();

    wait_drained();
    repeat (ENTRIES + 8) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
